// ===== rtl/leb_pkg.sv =====
`default_nettype none

package leb_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned HalfWidth  = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned GroupBits  = 7;
  localparam int unsigned CountWidth = 4;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  localparam logic [CountWidth-1:0] MAX_BYTES_32 = 4'd5;
  localparam logic [CountWidth-1:0] MAX_BYTES_64 = 4'd10;

  localparam logic [ByteWidth-1:0] CONT_BIT = 8'h80;

  typedef struct packed {
    logic                  kind;
    logic [ByteWidth-1:0]  byte_out;
    logic [ValueWidth-1:0] value_out;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/varint_leb128_codec.sv =====
`default_nettype none

// Unsigned LEB128 varint codec, 32-bit or 64-bit mode selected by the one config bit.
// A decode item (tuser = 1) feeds one byte; a result item carrying
// the value comes out when a byte has no continuation bit or the mode's byte limit is
// hit. An encode item (tuser = 0) gives an n-byte encoding (1 to 5 in
// 32-bit mode, 1 to 10 in 64-bit mode): the work register shifts out one 7-bit group
// per cycle into the output register while that register can take it. Results are
// registered there. Change the mode only while no item is in flight.
module varint_leb128_codec (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,      // long_mode
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [71:0] s_axis_tdata_i,   // value_in [63:0], byte_in [71:64]
  input  wire logic        s_axis_tuser_i,   // op
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [71:0] m_axis_tdata_o,   // byte_out [7:0], value_out [71:8]
  output logic             m_axis_tuser_o,   // kind
  output logic             m_axis_tlast_o    // last
);
  import leb_pkg::*;

  logic                  long_mode_q;
  logic                  work_valid_q;
  logic                  work_op_q;
  logic [ValueWidth-1:0] work_val_q;
  logic [ByteWidth-1:0]  work_byte_q;
  logic                  out_valid_q;
  result_t               out_q, out_d;

  logic                  slot_free;
  logic                  dec_done;
  logic [ValueWidth-1:0] dec_value;
  logic                  is_dec;
  logic                  fire;
  logic                  emit;
  logic                  finish;
  logic                  accept;
  logic [ValueWidth-1:0] enc_rem;
  logic                  enc_last;
  logic [ValueWidth-1:0] in_value;

  assign is_dec    = (work_op_q == OP_DECODE);
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign enc_rem   = work_val_q >> GroupBits;
  assign enc_last  = (enc_rem == '0);
  assign fire      = work_valid_q && (slot_free || (is_dec && !dec_done));
  assign emit      = fire && (!is_dec || dec_done);
  assign finish    = fire && (is_dec || enc_last);

  assign s_axis_tready_o = !work_valid_q || finish;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_value = long_mode_q ? s_axis_tdata_i[ValueWidth-1:0]
                                : {{HalfWidth{1'b0}}, s_axis_tdata_i[HalfWidth-1:0]};

  leb_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .long_mode_i (long_mode_q),
    .step_i      (fire && is_dec),
    .byte_i      (work_byte_q),
    .done_o      (dec_done),
    .value_o     (dec_value)
  );

  always_comb begin
    if (is_dec) begin
      out_d.kind      = KIND_VALUE;
      out_d.byte_out  = '0;
      out_d.value_out = dec_value;
      out_d.last      = 1'b1;
    end else begin
      out_d.kind      = KIND_BYTE;
      out_d.byte_out  = {!enc_last, work_val_q[GroupBits-1:0]};
      out_d.value_out = '0;
      out_d.last      = enc_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode_q  <= 1'b0;
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        long_mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        work_valid_q <= 1'b1;
      end else if (finish) begin
        work_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_op_q   <= s_axis_tuser_i;
      work_val_q  <= in_value;
      work_byte_q <= s_axis_tdata_i[71:64];
    end else if (fire && !finish) begin
      work_val_q  <= enc_rem;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.value_out, out_q.byte_out};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;

  // continuation bit is set exactly on the bytes that are not last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.kind == KIND_BYTE) |-> (out_q.byte_out[ByteWidth-1] == !out_q.last))
    else $error("encoded byte continuation disagrees with last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.kind == KIND_VALUE) |-> out_q.last && (out_q.byte_out == '0))
    else $error("decoded value item malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_valid_q && !finish |=> work_valid_q)
    else $error("work item dropped before it finished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("result written over an untaken result");

endmodule

`default_nettype wire

// ===== rtl/leb_dec.sv =====
`default_nettype none

module leb_dec (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           long_mode_i,
  input  wire logic                           step_i,
  input  wire logic [leb_pkg::ByteWidth-1:0]  byte_i,
  output logic                                done_o,
  output logic      [leb_pkg::ValueWidth-1:0] value_o
);
  import leb_pkg::*;

  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] count_inc;
  logic [CountWidth-1:0] max_bytes;
  logic [6:0]            shift_full;
  logic [5:0]            shift;
  logic [ValueWidth-1:0] acc_next;

  // bit offset of the incoming group, at most 63
  assign shift_full = {3'b000, count_q} * 7'd7;
  assign shift      = shift_full[5:0];
  assign acc_next   = acc_q | ({{(ValueWidth-GroupBits){1'b0}}, byte_i[GroupBits-1:0]} << shift);
  assign count_inc  = count_q + 4'd1;
  assign max_bytes  = long_mode_i ? MAX_BYTES_64 : MAX_BYTES_32;
  assign done_o     = !byte_i[ByteWidth-1] || (count_inc >= max_bytes);
  assign value_o    = long_mode_i ? acc_next : {{HalfWidth{1'b0}}, acc_next[HalfWidth-1:0]};

  always_comb begin
    acc_d   = acc_q;
    count_d = count_q;
    if (step_i) begin
      if (done_o) begin
        acc_d   = '0;
        count_d = '0;
      end else begin
        acc_d   = acc_next;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      count_q <= '0;
    end else begin
      acc_q   <= acc_d;
      count_q <= count_d;
    end
  end

  // count wraps back to zero before it could reach the longest run
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q < MAX_BYTES_64)
    else $error("decode byte count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done_o |=> (count_q == '0) && (acc_q == '0))
    else $error("decoder state not cleared after a value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !done_o |=> (count_q == $past(count_inc)))
    else $error("decode byte count did not advance");

endmodule

`default_nettype wire

// ===== sim/tb_varint_leb128_codec.sv =====
module tb_varint_leb128_codec;
  import leb_pkg::*;

  localparam int unsigned TargetItems = 320;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned WatchLimit  = 3000;
  localparam int unsigned PrintLimit  = 40;

  class codec_scoreboard;
    logic                  long_mode;
    logic [ValueWidth-1:0] gathered;
    logic [CountWidth-1:0] nbytes;
    result_t               pending_results[$];
    int unsigned           errors;
    int unsigned           encodes_taken;
    int unsigned           decodes_taken;
    int unsigned           bytes_seen;
    int unsigned           values_seen;

    function new();
      long_mode     = 1'b0;
      gathered      = '0;
      nbytes        = '0;
      errors        = 0;
      encodes_taken = 0;
      decodes_taken = 0;
      bytes_seen    = 0;
      values_seen   = 0;
    endfunction

    function void predict_encode(logic [ValueWidth-1:0] value);
      logic [ValueWidth-1:0] rest;
      logic [CountWidth-1:0] limit;
      logic                  more;
      result_t               r;
      rest  = long_mode ? value : {{HalfWidth{1'b0}}, value[HalfWidth-1:0]};
      limit = long_mode ? MAX_BYTES_64 : MAX_BYTES_32;
      for (int n = 0; n < limit; n++) begin
        r.kind      = KIND_BYTE;
        r.value_out = '0;
        r.byte_out  = {1'b0, rest[GroupBits-1:0]};
        rest        = rest >> GroupBits;
        more        = (rest != '0);
        if (more) begin
          r.byte_out = r.byte_out | CONT_BIT;
        end
        r.last = !more;
        pending_results.push_back(r);
        if (!more) begin
          break;
        end
      end
    endfunction

    function void predict_decode(logic [ByteWidth-1:0] b);
      logic [ValueWidth-1:0] group;
      logic [CountWidth:0]   taken;
      logic [CountWidth-1:0] limit;
      int unsigned           shift;
      result_t               r;
      limit = long_mode ? MAX_BYTES_64 : MAX_BYTES_32;
      group = {{(ValueWidth-GroupBits){1'b0}}, b[GroupBits-1:0]};
      shift = nbytes * GroupBits;
      if (shift < ValueWidth) begin
        gathered = gathered | (group << shift);
      end
      taken = {1'b0, nbytes} + 1'b1;
      if ((b & CONT_BIT) == '0 || taken >= {1'b0, limit}) begin
        r.kind      = KIND_VALUE;
        r.byte_out  = '0;
        r.value_out = long_mode ? gathered : {{HalfWidth{1'b0}}, gathered[HalfWidth-1:0]};
        r.last      = 1'b1;
        pending_results.push_back(r);
        gathered = '0;
        nbytes   = '0;
      end else begin
        nbytes = taken[CountWidth-1:0];
      end
    endfunction

    function void take_item(logic op, logic [ValueWidth-1:0] value, logic [ByteWidth-1:0] b);
      if (op == OP_ENCODE) begin
        encodes_taken++;
        predict_encode(value);
      end else begin
        decodes_taken++;
        predict_decode(b);
      end
    endfunction

    task report(string what, logic [ValueWidth-1:0] got, logic [ValueWidth-1:0] want);
      if (errors < PrintLimit) begin
        $display("error: %s got %h want %h at %0t", what, got, want, $realtime);
      end
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result, tdata", got.value_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.kind == KIND_VALUE) begin
          values_seen++;
        end else begin
          bytes_seen++;
        end
        if (got.kind !== want.kind) begin
          report("kind", 64'(got.kind), 64'(want.kind));
        end
        if (got.byte_out !== want.byte_out) begin
          report("byte_out", 64'(got.byte_out), 64'(want.byte_out));
        end
        if (got.value_out !== want.value_out) begin
          report("value_out", got.value_out, want.value_out);
        end
        if (got.last !== want.last) begin
          report("last", 64'(got.last), 64'(want.last));
        end
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_valid;
  logic [71:0] s_data;
  logic        s_op;
  logic        m_tready;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  codec_scoreboard sb;
  bit              tx_steady;
  bit              rx_steady;
  bit              rx_hold;
  int unsigned     items_sent;
  int unsigned     mode_writes;
  int unsigned     quiet_cycles;

  varint_leb128_codec i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_op),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ValueWidth-1:0] rand_value();
    logic [ValueWidth-1:0] v;
    int unsigned           nbits;
    v     = {$urandom, $urandom};
    nbits = $urandom_range(0, ValueWidth);
    if (nbits < ValueWidth) begin
      v = v & ((64'd1 << nbits) - 64'd1);
    end
    return v;
  endfunction

  task automatic send_item(input logic op, input logic [ValueWidth-1:0] value,
                           input logic [ByteWidth-1:0] b);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {b, value};
    s_op    <= op;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready_o) begin
        break;
      end
    end
    sb.take_item(op, value, b);
    items_sent++;
  endtask

  task automatic send_decode_run(input int unsigned len, input bit cont_on_final);
    logic [ByteWidth-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      b    = 8'($urandom_range(0, 255));
      b[7] = (i + 1 < len) ? 1'b1 : cont_on_final;
      send_item(OP_DECODE, {$urandom, $urandom}, b);
    end
  endtask

  // sender pauses until every result is back, then lets the pipe settle
  task automatic drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk_i);
    sb.long_mode = mode;
    mode_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        rx_hold = 1'b0;
        m_tready <= 1'b1;
      end else begin
        stall = rx_steady ? 0 : pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_tready) begin
        got.kind      = m_axis_tuser_o;
        got.byte_out  = m_axis_tdata_o[7:0];
        got.value_out = m_axis_tdata_o[71:8];
        got.last      = m_axis_tlast_o;
        sb.check_result(got);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < WatchLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no handshake for %0d cycles", WatchLimit);
    $display("varint_leb128_codec: mismatch");
    $finish;
  end

  initial begin
    int unsigned     phase;
    int unsigned     phase_end;
    int unsigned     sel;
    int unsigned     len;
    logic [CountWidth-1:0] limit;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = 1'b0;
    s_valid     = 1'b0;
    s_data      = '0;
    s_op        = OP_ENCODE;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    rx_hold     = 1'b0;
    items_sent  = 0;
    mode_writes = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // 32-bit mode from reset: zero, one continuation, masked upper half
    send_item(OP_ENCODE, 64'h0, 8'h00);
    send_item(OP_ENCODE, 64'h80, 8'hff);
    send_item(OP_ENCODE, 64'ha5a5_a5a5_ffff_ffff, 8'h00);
    send_item(OP_DECODE, 64'hffff_ffff_ffff_ffff, 8'h00);
    // byte limit reached with continuation still set
    send_decode_run(5, 1'b1);
    drain();
    write_mode(1'b1);
    send_item(OP_ENCODE, 64'hffff_ffff_ffff_ffff, 8'h55);
    // tenth byte only keeps bit 0
    send_item(OP_DECODE, 64'h0, 8'hff);
    send_decode_run(9, 1'b1);
    drain();
    // mode change in mid-decode: six bytes kept, next byte completes at once
    send_decode_run(6, 1'b1);
    drain();
    write_mode(1'b0);
    send_item(OP_DECODE, 64'h0, 8'hd5);

    phase = 0;
    while (items_sent < TargetItems) begin
      drain();
      write_mode(1'($urandom_range(0, 1)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        // receiver holds off while sender keeps pushing
        tx_steady = 1'b1;
        rx_hold   = 1'b1;
      end
      limit     = sb.long_mode ? MAX_BYTES_64 : MAX_BYTES_32;
      phase_end = items_sent + $urandom_range(15, 45);
      while (items_sent < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          send_item(OP_ENCODE, rand_value(), 8'($urandom_range(0, 255)));
        end else if (sel < 85) begin
          len = $urandom_range(1, 32'(limit));
          send_decode_run(len, (len == limit) && ($urandom_range(0, 1) == 1));
        end else begin
          send_item(OP_DECODE, {$urandom, $urandom}, 8'($urandom_range(0, 255)));
        end
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d encode and %0d decode items over %0d mode writes",
             sb.encodes_taken, sb.decodes_taken, mode_writes);
    $display("checked %0d encoded bytes and %0d decoded values, %0d errors",
             sb.bytes_seen, sb.values_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("varint_leb128_codec: match");
    end else begin
      $display("varint_leb128_codec: mismatch");
    end
    $finish;
  end

endmodule
